// File: rtl/core/tcc_pkg.sv
// Shared types and constants for the text console cursor controller.
package tcc_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLUMNS    = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ROWS_COUNT = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH_PX  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT_PX = 4'd3;
	localparam int unsigned CFG_DATA_W = 8;

	// register reset values
	localparam logic [7:0] RST_TEXT_COLUMNS    = 8'd80;
	localparam logic [7:0] RST_TEXT_ROWS_COUNT = 8'd25;
	localparam logic [5:0] RST_GLYPH_WIDTH_PX  = 6'd12;
	localparam logic [6:0] RST_GLYPH_HEIGHT_PX = 7'd24;

	// character codes
	localparam logic [7:0] CHAR_BS    = 8'd8;
	localparam logic [7:0] CHAR_HT    = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] PRINT_LO   = 8'd32;
	localparam logic [7:0] PRINT_HI   = 8'd126;
	localparam logic [6:0] GLYPH_SPACE = 7'd32;

	// tab stops on multiples of eight
	localparam logic [8:0] TAB_STEP = 9'd8;
	localparam logic [8:0] TAB_MASK = ~(TAB_STEP - 9'd1);

	typedef struct packed {
		logic [7:0] text_columns;
		logic [7:0] text_rows_count;
		logic [5:0] glyph_width_px;
		logic [6:0] glyph_height_px;
	} geom_t;

	typedef struct packed {
		logic        draw_glyph;
		logic [6:0]  glyph_code;
		logic [12:0] origin_x;
		logic [13:0] origin_y;
		logic        scroll_up;
		logic [7:0]  cursor_column;
		logic [7:0]  cursor_row;
	} step_result_t;

endpackage

// File: rtl/core/tcc_step.sv
// Cursor update and glyph origin for one character byte.
module tcc_step (
	input  logic [7:0]           char_byte,
	input  logic [7:0]           column,
	input  logic [7:0]           row,
	input  tcc_pkg::geom_t       geom,
	output tcc_pkg::step_result_t result
);
	import tcc_pkg::*;

	logic [7:0]  cols;
	logic [7:0]  rows;
	logic [8:0]  col_n;
	logic [8:0]  row_n;
	logic [7:0]  cell_col;
	logic        draw;
	logic [6:0]  code;
	logic        scroll;
	logic [13:0] prod_x;
	logic [14:0] prod_y;

	// zero geometry behaves as one cell
	assign cols = (geom.text_columns == 8'd0) ? 8'd1 : geom.text_columns;
	assign rows = (geom.text_rows_count == 8'd0) ? 8'd1 : geom.text_rows_count;

	always_comb begin
		col_n    = {1'b0, column};
		row_n    = {1'b0, row};
		cell_col = column;
		draw     = 1'b0;
		code     = '0;
		case (char_byte)
			CHAR_LF: begin
				col_n = '0;
				row_n = {1'b0, row} + 9'd1;
			end
			CHAR_CR: begin
				col_n = '0;
			end
			CHAR_BS: begin
				if (column != 8'd0) begin
					cell_col = column - 8'd1;
					col_n    = {1'b0, cell_col};
					draw     = 1'b1;
					code     = GLYPH_SPACE;
				end
			end
			CHAR_HT: begin
				col_n = ({1'b0, column} + TAB_STEP) & TAB_MASK;
			end
			default: begin
				if (char_byte inside {[PRINT_LO:PRINT_HI]}) begin
					draw  = 1'b1;
					code  = char_byte[6:0];
					col_n = {1'b0, column} + 9'd1;
				end
			end
		endcase

		// wrap, then scroll; row_n cannot exceed 256 here
		if (col_n >= {1'b0, cols}) begin
			col_n = '0;
			row_n = row_n + 9'd1;
		end
		scroll = 1'b0;
		if (row_n >= {1'b0, rows}) begin
			scroll = 1'b1;
			row_n  = {1'b0, rows - 8'd1};
		end
	end

	assign prod_x = {6'd0, cell_col} * {8'd0, geom.glyph_width_px};
	assign prod_y = {7'd0, row} * {8'd0, geom.glyph_height_px};

	always_comb begin
		result.draw_glyph    = draw;
		result.glyph_code    = code;
		result.origin_x      = draw ? prod_x[12:0] : 13'd0;
		result.origin_y      = draw ? prod_y[13:0] : 14'd0;
		result.scroll_up     = scroll;
		result.cursor_column = col_n[7:0];
		result.cursor_row    = row_n[7:0];
	end

endmodule

// File: rtl/core/text_console_cursor_control.sv
// Top level of the text console cursor controller.
//
//  channel   signals                         direction  payload
//  input     in_valid / in_ready             in         char_byte
//  output    out_valid / out_ready           out        draw_glyph .. cursor_row
//  config    cfg_write, cfg_index, cfg_data  in         register write, no wait
//
// One byte per cycle while out_ready is high; input register, then result register.
// The cursor update and both origin multiplies sit between those two registers.
// Reset clears the cursor to column 0, row 0 and loads the default geometry.
// With out_ready low the result holds and the input register takes one more
// transaction before in_ready falls.
module text_console_cursor_control (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              draw_glyph,
	output logic [6:0]                        glyph_code,
	output logic [12:0]                       origin_x,
	output logic [13:0]                       origin_y,
	output logic                              scroll_up,
	output logic [7:0]                        cursor_column,
	output logic [7:0]                        cursor_row,
	input  logic                              cfg_write,
	input  logic [tcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tcc_pkg::*;

	geom_t        geom_q;
	logic [7:0]   column_q;
	logic [7:0]   row_q;
	logic [7:0]   char_s1;
	logic         valid_s1;
	step_result_t step_res;
	step_result_t res_s2;
	logic         valid_s2;
	logic         advance;
	logic         take_in;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.text_columns    <= RST_TEXT_COLUMNS;
			geom_q.text_rows_count <= RST_TEXT_ROWS_COUNT;
			geom_q.glyph_width_px  <= RST_GLYPH_WIDTH_PX;
			geom_q.glyph_height_px <= RST_GLYPH_HEIGHT_PX;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TEXT_COLUMNS:    geom_q.text_columns    <= cfg_data[7:0];
				REG_TEXT_ROWS_COUNT: geom_q.text_rows_count <= cfg_data[7:0];
				REG_GLYPH_WIDTH_PX:  geom_q.glyph_width_px  <= cfg_data[5:0];
				REG_GLYPH_HEIGHT_PX: geom_q.glyph_height_px <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	tcc_step u_step (
		.char_byte (char_s1),
		.column    (column_q),
		.row       (row_q),
		.geom      (geom_q),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			column_q <= '0;
			row_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				column_q <= step_res.cursor_column;
				row_q    <= step_res.cursor_row;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= char_byte;
		end
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid     = valid_s2;
	assign draw_glyph    = res_s2.draw_glyph;
	assign glyph_code    = res_s2.glyph_code;
	assign origin_x      = res_s2.origin_x;
	assign origin_y      = res_s2.origin_y;
	assign scroll_up     = res_s2.scroll_up;
	assign cursor_column = res_s2.cursor_column;
	assign cursor_row    = res_s2.cursor_row;

endmodule

// File: dv/text_console_cursor_control_test.sv
// Self-checking testbench for the text console cursor controller.
module text_console_cursor_control_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcc_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned END_SETTLE  = 10;
	localparam int unsigned PHASES      = 12;
	localparam int unsigned QUIET_PHASES = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_GLYPH_HEIGHT_PX + 1'b1;
	localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = {CFG_INDEX_W{1'b1}};

	typedef enum {GEO_SMALL, GEO_TALL, GEO_MAX, GEO_ZERO, GEO_ANY, GEO_DEFAULT} geom_kind_t;
	typedef enum {FOCUS_TEXT, FOCUS_NEWLINE, FOCUS_TAB, FOCUS_BACKSPACE} char_focus_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             char_byte = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   draw_glyph;
	logic [6:0]             glyph_code;
	logic [12:0]            origin_x;
	logic [13:0]            origin_y;
	logic                   scroll_up;
	logic [7:0]             cursor_column;
	logic [7:0]             cursor_row;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// predicted block state
	geom_t        geom = '{text_columns: RST_TEXT_COLUMNS, text_rows_count: RST_TEXT_ROWS_COUNT,
		glyph_width_px: RST_GLYPH_WIDTH_PX, glyph_height_px: RST_GLYPH_HEIGHT_PX};
	logic [7:0]   cur_col = '0;
	logic [7:0]   cur_row = '0;
	step_result_t pending_cursor_updates[$];

	bit           pacing_on = 1'b0;
	int unsigned  sink_hold = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  chars_sent = 0;
	int unsigned  results_checked = 0;
	int unsigned  geometry_count = 0;

	text_console_cursor_control dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .char_byte,
		.out_valid, .out_ready,
		.draw_glyph, .glyph_code, .origin_x, .origin_y, .scroll_up,
		.cursor_column, .cursor_row,
		.cfg_write, .cfg_index, .cfg_data
	);

	always #4 clk = ~clk;

	function automatic step_result_t advance_cursor(input logic [7:0] ch);
		step_result_t r;
		int unsigned  cols, rows, col, row;
		cols = (geom.text_columns == 0) ? 1 : 32'(geom.text_columns);
		rows = (geom.text_rows_count == 0) ? 1 : 32'(geom.text_rows_count);
		col = 32'(cur_col);
		row = 32'(cur_row);
		r = '0;
		if (ch == CHAR_LF) begin
			col = 0;
			row = row + 1;
		end else if (ch == CHAR_CR) begin
			col = 0;
		end else if (ch == CHAR_BS) begin
			// nothing to rub out at the left margin
			if (col > 0) begin
				col = col - 1;
				r.draw_glyph = 1'b1;
				r.glyph_code = GLYPH_SPACE;
				r.origin_x = 13'(col * geom.glyph_width_px);
				r.origin_y = 14'(row * geom.glyph_height_px);
			end
		end else if (ch == CHAR_HT) begin
			col = (col + 32'(TAB_STEP)) & ~(32'(TAB_STEP) - 1);
		end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
			r.draw_glyph = 1'b1;
			r.glyph_code = ch[6:0];
			r.origin_x = 13'(col * geom.glyph_width_px);
			r.origin_y = 14'(row * geom.glyph_height_px);
			col = col + 1;
		end
		if (col >= cols) begin
			col = 0;
			row = row + 1;
		end
		if (row >= rows) begin
			r.scroll_up = 1'b1;
			row = rows - 1;
		end
		cur_col = col[7:0];
		cur_row = row[7:0];
		r.cursor_column = cur_col;
		r.cursor_row = cur_row;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cursor_updates.size() == 0) begin
				$error("result transaction with no byte outstanding");
				mismatch_count++;
			end else begin
				want = pending_cursor_updates.pop_front();
				check_field("draw_glyph", 32'(want.draw_glyph), 32'(draw_glyph));
				check_field("glyph_code", 32'(want.glyph_code), 32'(glyph_code));
				check_field("origin_x", 32'(want.origin_x), 32'(origin_x));
				check_field("origin_y", 32'(want.origin_y), 32'(origin_y));
				check_field("scroll_up", 32'(want.scroll_up), 32'(scroll_up));
				check_field("cursor_column", 32'(want.cursor_column), 32'(cursor_column));
				check_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
				results_checked++;
			end
		end
	end

	// back-pressure in random bursts
	always @(posedge clk) begin : sink_pacing
		int unsigned hold;
		hold = sink_hold;
		if (hold != 0)
			hold = hold - 1;
		else if (pacing_on && $urandom_range(0, 7) == 0)
			hold = $urandom_range(1, 14);
		sink_hold <= hold;
		out_ready <= (hold == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// valid is left high after a transaction so back-to-back bytes need no toggle
	task automatic send_char(input logic [7:0] ch);
		int unsigned gap;
		if (pacing_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_cursor_updates.push_back(advance_cursor(ch));
		chars_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cursor_updates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_TEXT_COLUMNS:    geom.text_columns = data;
			REG_TEXT_ROWS_COUNT: geom.text_rows_count = data;
			REG_GLYPH_WIDTH_PX:  geom.glyph_width_px = data[5:0];
			REG_GLYPH_HEIGHT_PX: geom.glyph_height_px = data[6:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows,
		input logic [7:0] gw, input logic [7:0] gh);
		drain_results();
		write_reg(REG_TEXT_COLUMNS, cols);
		write_reg(REG_TEXT_ROWS_COUNT, rows);
		write_reg(REG_GLYPH_WIDTH_PX, gw);
		write_reg(REG_GLYPH_HEIGHT_PX, gh);
		// a stray index must leave the geometry alone
		write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
			8'($urandom_range(0, 255)));
		cfg_write <= 1'b0;
		geometry_count++;
	endtask

	function automatic logic [7:0] random_char(input char_focus_t focus);
		int unsigned pick;
		logic [7:0]  printable;
		pick = $urandom_range(0, 99);
		printable = 8'($urandom_range(PRINT_LO, PRINT_HI));
		if (pick < 35) begin
			case (focus)
				FOCUS_NEWLINE:   return CHAR_LF;
				FOCUS_TAB:       return CHAR_HT;
				FOCUS_BACKSPACE: return CHAR_BS;
				default:         return printable;
			endcase
		end
		if (pick < 70)
			return printable;
		if (pick < 75)
			return CHAR_BS;
		if (pick < 80)
			return CHAR_HT;
		if (pick < 85)
			return CHAR_LF;
		if (pick < 90)
			return CHAR_CR;
		return 8'($urandom_range(0, 255));
	endfunction

	// default geometry straight out of reset
	task automatic test_control_codes();
		send_char(CHAR_BS);
		send_char(PRINT_LO);
		send_char(PRINT_HI);
		send_char(CHAR_BS);
		send_char(CHAR_HT);
		send_char(CHAR_CR);
		send_char(CHAR_LF);
		send_char(8'd0);
		send_char(8'd127);
		send_char(8'd255);
		send_char(PRINT_LO - 8'd1);
		send_char(8'd128);
		send_char("A");
	endtask

	task automatic test_zero_and_full_geometry();
		set_geometry(8'd0, 8'd0, 8'd0, 8'd0);
		send_char("x");
		send_char(CHAR_BS);
		// all ones: glyph sizes are cut to their register width
		set_geometry(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_char(CHAR_HT);
		send_char("Z");
		send_char(CHAR_BS);
	endtask

	task automatic test_cursor_outside_screen();
		set_geometry(8'd40, 8'd10, 8'd8, 8'd16);
		send_char(CHAR_LF);
		send_char(CHAR_LF);
		send_char(CHAR_HT);
		send_char(CHAR_HT);
		send_char(CHAR_HT);
		// shrink the screen under the cursor
		set_geometry(8'd4, 8'd3, 8'd8, 8'd16);
		send_char("q");
		send_char(CHAR_BS);
	endtask

	task automatic test_random_text();
		geom_kind_t  kind;
		char_focus_t focus;
		int unsigned count;
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			kind = (phase <= GEO_DEFAULT) ? geom_kind_t'(phase)
				: geom_kind_t'($urandom_range(GEO_SMALL, GEO_DEFAULT));
			focus = char_focus_t'($urandom_range(FOCUS_TEXT, FOCUS_BACKSPACE));
			count = 90;
			case (kind)
				GEO_SMALL: begin
					set_geometry(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
				GEO_TALL: begin
					// one cell per row walks the cursor down to the last row
					set_geometry(8'($urandom_range(0, 1)), 8'hFF, 8'($urandom_range(0, 255)),
						8'hFF);
					focus = FOCUS_NEWLINE;
					count = 250;
				end
				GEO_MAX: begin
					set_geometry(8'hFF, 8'hFF, 8'hFF, 8'hFF);
					focus = FOCUS_TAB;
				end
				GEO_ZERO: set_geometry(8'd0, 8'd0, 8'd0, 8'd0);
				GEO_ANY: begin
					set_geometry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
				default: begin
					set_geometry(RST_TEXT_COLUMNS, RST_TEXT_ROWS_COUNT, 8'(RST_GLYPH_WIDTH_PX),
						8'(RST_GLYPH_HEIGHT_PX));
				end
			endcase
			pacing_on = (phase < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
			repeat (count)
				send_char(random_char(focus));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		pacing_on = 1'b1;
		test_control_codes();
		test_zero_and_full_geometry();
		test_cursor_outside_screen();
		// hold the sender until the pipeline has emptied
		drain_results();
		test_random_text();
		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		$display("%0d bytes sent, %0d results checked over %0d geometry settings",
			chars_sent, results_checked, geometry_count);
		$display("control codes, wrap, scroll, zero and full geometry, origin wrap-around");
		if (mismatch_count == 0 && pending_cursor_updates.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
